// ----- src/lru_key_value_cache_core_macros.svh -----
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared property shorthands, clocked on clock and idle during reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LRUKV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LRUKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/lrukv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_pkg
// shared constants and types of the lru key-value cache
// ----------------------------------------------------------------------------
package lrukv_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam int CAP_BITS      = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
   localparam int DATA_OUT_BITS = 32;

   localparam logic ACT_READ = 1'b0;
   localparam logic ACT_ADD  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // per-cell update command from the controller
   typedef struct packed {
      logic load;      // take key and value from the neighbor toward the front
      logic valid_we;  // rewrite the valid flag
      logic valid_d;
   } cell_ctl_type;

endpackage

// ----- src/lru_key_value_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat: a read lookup or an add of a record.
//   rsp_* returns exactly one beat per command: found and data_out for a
//   read, accepted for an add. csr_* writes the capacity register; it is
//   always ready and should only be written while no command is in flight.
//   An accepted command beat is registered and moves the block to execute;
//   its outcome is registered into rsp_*. The slot row is read and rewritten
//   in the execute cycle that follows each accepted beat; no new beat is taken
//   until idle again, as the next command must compare against the reordered row.
//   Slots sit in a row ordered by recency; a hit shifts the row up to the hit
//   slot by one cell toward the back in that cycle, and an add shifts it all.
//   Reset clears all valid flags, the occupancy and the result valid flag,
//   and sets capacity to 16. No clearing pass is needed.
//   While rsp_stall holds a result, a new command beat is only taken once the
//   held result leaves, so at most one result ever waits.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_core_macros.svh"

module lru_key_value_cache_core import lrukv_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [KEY_BITS-1:0]      req_lookup_key,
   input  logic [VALUE_BITS-1:0]    req_record_value,
   input  logic                     req_key_empty,
   input  logic                     req_value_empty,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [DATA_OUT_BITS-1:0] rsp_data_out,
   output logic                     rsp_accepted,
   // capacity register
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_BITS-1:0]      csr_capacity
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = ((OCC_W > CAP_BITS) ? OCC_W : CAP_BITS) + 1;

   state_type state_ff, state_in;

   logic                  act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  kempty_ff;
   logic                  vempty_ff;

   logic [CAP_BITS-1:0] cap_ff;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff;
   logic [DATA_OUT_BITS-1:0] data_ff;
   logic                     accepted_ff;

   logic req_take;
   logic exec;

   logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0] cell_value [ENTRIES];
   logic [KEY_BITS-1:0]   prev_key   [ENTRIES];
   logic [VALUE_BITS-1:0] prev_value [ENTRIES];
   logic [ENTRIES-1:0]    valid_vec;
   logic [ENTRIES-1:0]    match_vec;
   cell_ctl_type          ctl        [ENTRIES];

   logic                  any_match;
   logic [IDX_W-1:0]      hit_idx;
   logic [VALUE_BITS-1:0] hit_value;
   logic                  rd_hit;
   logic                  add_ok;
   logic                  evict;
   logic [CMP_W-1:0]      eff_cap;

   // ---------------- handshakes and control ----------------

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign exec      = (state_ff == ST_EXEC);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= CAP_RESET;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (csr_valid && csr_ready) cap_ff <= csr_capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff    <= req_action;
         key_ff    <= req_lookup_key;
         value_ff  <= req_record_value;
         kempty_ff <= req_key_empty;
         vempty_ff <= req_value_empty;
      end
   end

   // ---------------- lookup and update decision ----------------

   lrukv_hit_sel #(
      .ENTRIES    (ENTRIES),
      .VALUE_BITS (VALUE_BITS)
   ) u_hit_sel (
      .match     (match_vec),
      .values    (cell_value),
      .hit       (any_match),
      .hit_idx   (hit_idx),
      .hit_value (hit_value)
   );

   // capacity zero acts as one, anything above the slot count saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign rd_hit = (act_ff == ACT_READ) && !kempty_ff && any_match;
   assign add_ok = (act_ff == ACT_ADD) && !kempty_ff && !vempty_ff && !any_match;
   assign evict  = (CMP_W'(occ_ff) >= eff_cap) && (occ_ff != '0);

   always_comb begin
      occ_in = occ_ff;
      if (exec && add_ok && !evict) occ_in = occ_ff + OCC_W'(1);
   end

   // ---------------- slot row ----------------

   assign prev_key[0]   = key_ff;
   assign prev_value[0] = (act_ff == ACT_ADD) ? value_ff : hit_value;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign prev_key[i]   = cell_key[i-1];
         assign prev_value[i] = cell_value[i-1];
      end

      // a hit pulls the front part down to the hit slot, an add shifts all
      assign ctl[i].load     = exec && (add_ok || (rd_hit && (IDX_W'(i) <= hit_idx)));
      assign ctl[i].valid_we = exec && add_ok;
      assign ctl[i].valid_d  = (OCC_W'(i) < occ_in);

      lrukv_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[i]),
         .cmp_key    (key_ff),
         .prev_key   (prev_key[i]),
         .prev_value (prev_value[i]),
         .cell_key   (cell_key[i]),
         .cell_value (cell_value[i]),
         .cell_valid (valid_vec[i]),
         .cell_match (match_vec[i])
      );
   end

   // ---------------- result register ----------------

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (exec) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         found_ff    <= rd_hit;
         data_ff     <= rd_hit ? DATA_OUT_BITS'(hit_value) : '0;
         accepted_ff <= add_ok;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_data_out = data_ff;
   assign rsp_accepted = accepted_ff;

   // ---------------- assertions ----------------

   `LRUKV_ASSERT_NOW(a_match_unique, exec, $onehot0(match_vec), "more than one slot matched")
   `LRUKV_ASSERT_NOW(a_valid_count, 1'b1, $countones(valid_vec) == occ_ff,
      "valid flags disagree with occupancy")
   `LRUKV_ASSERT_NEXT(a_exec_result, exec, rsp_valid_ff, "execute cycle left no result")
   `LRUKV_ASSERT_NOW(a_result_free, exec, !rsp_valid_ff, "result register busy at execute")
   `LRUKV_ASSERT_NOW(a_found_xor_add, rsp_valid_ff, !(found_ff && accepted_ff),
      "result both found and accepted")

endmodule

// ----- src/lrukv_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_cell
// one recency slot: holds a key, a value and a valid flag, compares its key
// against the broadcast lookup key and loads from its front neighbor on command
// ----------------------------------------------------------------------------
module lrukv_cell import lrukv_pkg::*; #(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [KEY_BITS-1:0]   cmp_key,
   input  logic [KEY_BITS-1:0]   prev_key,
   input  logic [VALUE_BITS-1:0] prev_value,
   output logic [KEY_BITS-1:0]   cell_key,
   output logic [VALUE_BITS-1:0] cell_value,
   output logic                  cell_valid,
   output logic                  cell_match
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.valid_we) begin
         valid_ff <= ctl.valid_d;
      end
   end

   assign cell_key   = key_ff;
   assign cell_value = value_ff;
   assign cell_valid = valid_ff;
   assign cell_match = valid_ff && (key_ff == cmp_key);

endmodule

// ----- src/lrukv_hit_sel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukv_hit_sel
// turns the one-hot match row into a hit flag, the hit slot index and the
// value held in that slot
// ----------------------------------------------------------------------------
module lrukv_hit_sel import lrukv_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic [ENTRIES-1:0]         match,
   input  logic [VALUE_BITS-1:0]      values [ENTRIES],
   output logic                       hit,
   output logic [$clog2(ENTRIES)-1:0] hit_idx,
   output logic [VALUE_BITS-1:0]      hit_value
);

   localparam int IDX_W = $clog2(ENTRIES);

   // keys are unique among valid slots, so an or-reduction is a mux
   always_comb begin
      hit_idx   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            hit_idx   = hit_idx | IDX_W'(i);
            hit_value = hit_value | values[i];
         end
      end
   end

   assign hit = |match;

endmodule
